### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. Defining NO_ASSERTIONS compiles them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (prop)) \
		else $error("assertion %m failed");

// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion %m failed");

`else

`define ASSERT_ALWAYS(label, clock, rst_n, prop)
`define ASSERT_NEXT(label, clock, rst_n, ante, cons)

`endif

`endif

### rtl/core/msenc_pkg.sv
package msenc_pkg;

	localparam int unsigned LrcWidth   = 7;
	localparam int unsigned NbitsWidth = 3;
	localparam int unsigned ZeroWidth  = 5;
	localparam int unsigned CfgIdxWidth  = 2;
	localparam int unsigned CfgDataWidth = 8;

	localparam logic [NbitsWidth-1:0] DataBitsReset  = 3'd6;
	localparam logic [7:0]            CharOffsetReset = 8'd32;
	localparam logic [ZeroWidth-1:0]  LeadReset      = 5'd10;
	localparam logic [ZeroWidth-1:0]  TrailReset     = 5'd10;

	typedef enum logic [CfgIdxWidth-1:0] {
		CFG_DATA_BITS   = 2'd0,
		CFG_CHAR_OFFSET = 2'd1,
		CFG_LEAD_ZEROS  = 2'd2,
		CFG_TRAIL_ZEROS = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FUNC_BEGIN      = 2'd0,
		FUNC_DATA       = 2'd1,
		FUNC_END        = 2'd2,
		FUNC_RESET_POLE = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic pole_first_half;
		logic pole_second_half;
		logic cell_bit;
		logic last_cell;
	} out_item_t;

	typedef struct packed {
		logic [NbitsWidth-1:0] data_bits;
		logic [7:0]            char_offset;
		logic [ZeroWidth-1:0]  leading_zero_count;
		logic [ZeroWidth-1:0]  trailing_zero_count;
	} cfg_t;

	// One classified command as it waits between the front and the back.
	typedef struct packed {
		logic                  clr_pole;
		logic                  send_char;
		logic [LrcWidth-1:0]   value;
		logic [NbitsWidth-1:0] nbits;
		logic [ZeroWidth-1:0]  zeros;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE   = 2'd0,
		BK_DATA   = 2'd1,
		BK_PARITY = 2'd2,
		BK_ZERO   = 2'd3
	} back_state_t;

	typedef struct packed {
		logic idle;
		logic emit;
	} back_status_t;

endpackage

### rtl/core/msenc_front.sv
module msenc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  msenc_pkg::in_item_t item,
	input  msenc_pkg::cfg_t     cfg,
	output msenc_pkg::cmd_t     cmd
);

	logic [msenc_pkg::LrcWidth-1:0] lrc_q;
	logic [7:0]                      shifted;
	logic [msenc_pkg::LrcWidth-1:0] mask;

	assign shifted = item.char_code - cfg.char_offset;
	// Keep only the data bits that are actually sent.
	assign mask = 7'h7F >> (3'd7 - cfg.data_bits);

	always_comb begin
		cmd = '0;
		cmd.nbits = cfg.data_bits;
		case (msenc_pkg::func_t'(item.func))
			msenc_pkg::FUNC_BEGIN: begin
				cmd.zeros = cfg.leading_zero_count;
			end
			msenc_pkg::FUNC_DATA: begin
				cmd.send_char = 1'b1;
				cmd.value = shifted[msenc_pkg::LrcWidth-1:0];
			end
			msenc_pkg::FUNC_END: begin
				cmd.send_char = 1'b1;
				cmd.value = lrc_q;
				cmd.zeros = cfg.trailing_zero_count;
			end
			default: begin
				cmd.clr_pole = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lrc_q <= '0;
		end else if (accept) begin
			if (msenc_pkg::func_t'(item.func) == msenc_pkg::FUNC_BEGIN) begin
				lrc_q <= '0;
			end else if (msenc_pkg::func_t'(item.func) == msenc_pkg::FUNC_DATA) begin
				lrc_q <= lrc_q ^ (shifted[msenc_pkg::LrcWidth-1:0] & mask);
			end
		end
	end

endmodule

### rtl/core/msenc_queue.sv
module msenc_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  msenc_pkg::cmd_t  wdata,
	input  logic             pop,
	output msenc_pkg::cmd_t  rdata,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntWidth = $clog2(DEPTH + 1);
	localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
	localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

	msenc_pkg::cmd_t       mem_q [DEPTH];
	logic [PtrWidth-1:0]   wptr_q;
	logic [PtrWidth-1:0]   rptr_q;
	logic [CntWidth-1:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/msenc_back.sv
module msenc_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  msenc_pkg::cmd_t          head,
	input  logic                     q_empty,
	output logic                     q_pop,
	output msenc_pkg::out_item_t     bitcell,
	output logic                     empty,
	input  logic                     pop,
	output msenc_pkg::back_status_t  status
);

	msenc_pkg::back_state_t state_q;
	msenc_pkg::back_state_t state_d;

	logic [msenc_pkg::LrcWidth-1:0]   val_q;
	logic [msenc_pkg::NbitsWidth-1:0] nbits_q;
	logic [msenc_pkg::NbitsWidth-1:0] idx_q;
	logic [msenc_pkg::ZeroWidth-1:0]  zeros_q;
	logic                             par_q;
	logic                             pole_q;
	logic                             out_valid_q;
	msenc_pkg::out_item_t             out_q;

	logic adv;
	logic emit;
	logic emit_bit;
	logic emit_last;
	logic first_half;

	// A new cell may be produced when the output register is free or drains now.
	assign adv        = !out_valid_q || pop;
	assign first_half = !pole_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			msenc_pkg::BK_IDLE: begin
				if (!q_empty && !head.clr_pole) begin
					if (head.send_char) begin
						state_d = (head.nbits == '0) ? msenc_pkg::BK_PARITY
							: msenc_pkg::BK_DATA;
					end else if (head.zeros != '0) begin
						state_d = msenc_pkg::BK_ZERO;
					end
				end
			end
			msenc_pkg::BK_DATA: begin
				if (adv && idx_q == nbits_q - 1'b1) begin
					state_d = msenc_pkg::BK_PARITY;
				end
			end
			msenc_pkg::BK_PARITY: begin
				if (adv) begin
					state_d = (zeros_q == '0) ? msenc_pkg::BK_IDLE : msenc_pkg::BK_ZERO;
				end
			end
			msenc_pkg::BK_ZERO: begin
				if (adv && zeros_q == 5'd1) begin
					state_d = msenc_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = msenc_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_bit  = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			msenc_pkg::BK_IDLE: begin
				q_pop = !q_empty;
			end
			msenc_pkg::BK_DATA: begin
				emit     = adv;
				emit_bit = val_q[idx_q];
			end
			msenc_pkg::BK_PARITY: begin
				emit      = adv;
				emit_bit  = par_q;
				emit_last = (zeros_q == '0);
			end
			msenc_pkg::BK_ZERO: begin
				emit      = adv;
				emit_last = (zeros_q == 5'd1);
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msenc_pkg::BK_IDLE;
			pole_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && head.clr_pole) begin
				pole_q <= 1'b0;
			end else if (emit) begin
				pole_q <= first_half ^ emit_bit;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			val_q   <= head.value;
			nbits_q <= head.nbits;
			zeros_q <= head.zeros;
			idx_q   <= '0;
			par_q   <= 1'b1;
		end else begin
			if (state_q == msenc_pkg::BK_DATA && emit) begin
				par_q <= par_q ^ emit_bit;
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == msenc_pkg::BK_ZERO && emit) begin
				zeros_q <= zeros_q - 1'b1;
			end
		end
		if (emit) begin
			out_q.pole_first_half  <= first_half;
			out_q.pole_second_half <= first_half ^ emit_bit;
			out_q.cell_bit         <= emit_bit;
			out_q.last_cell        <= emit_last;
		end
	end

	assign bitcell     = out_q;
	assign empty       = !out_valid_q;
	assign status.idle = (state_q == msenc_pkg::BK_IDLE);
	assign status.emit = emit;

endmodule

### rtl/core/magstripe_f2f_track_encoder_core.sv
// A transferred command waits in the queue until the back end pops it while idle;
// its bit cells then pass through the output register to the result ports.
// Throughput: one bit cell per cycle from the serializer while the output register
// is free or drains, after each command is loaded in the idle state.
// Reset (arst_n low, asynchronous): pole and LRC cleared, queue empty,
// registers at their defaults (6 data bits, offset 32, 10 leading and trailing zeros).
`include "assert_macros.svh"

module magstripe_f2f_track_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  msenc_pkg::in_item_t                 item,
	output logic                                empty,
	input  logic                                pop,
	output msenc_pkg::out_item_t                bitcell,
	input  logic                                cfg_we,
	input  logic [msenc_pkg::CfgIdxWidth-1:0]   cfg_idx,
	input  logic [msenc_pkg::CfgDataWidth-1:0]  cfg_wdata
);

	// The block has three parts. The front classifies each incoming command and
	// keeps the running LRC, so that an end-of-track command carries the LRC as it
	// stood when the command arrived. The queue holds classified commands. The back
	// end serializes each command into F2F bit cells, tracks the coil pole and
	// keeps the newest cell in an output register, so a cell can wait for its
	// transfer while the next command is already being accepted.

	msenc_pkg::cfg_t          cfg_q;
	msenc_pkg::cmd_t          front_cmd;
	msenc_pkg::cmd_t          q_head;
	msenc_pkg::back_status_t  back_st;
	logic                     q_full;
	logic                     q_empty;
	logic                     q_pop;
	logic                     accept;

	assign accept = push && !q_full;
	assign full   = q_full;

	// Configuration registers. A write takes effect at once, so the user must issue
	// writes only while no command is in flight; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_bits           <= msenc_pkg::DataBitsReset;
			cfg_q.char_offset         <= msenc_pkg::CharOffsetReset;
			cfg_q.leading_zero_count  <= msenc_pkg::LeadReset;
			cfg_q.trailing_zero_count <= msenc_pkg::TrailReset;
		end else if (cfg_we) begin
			case (msenc_pkg::cfg_idx_t'(cfg_idx))
				msenc_pkg::CFG_DATA_BITS: begin
					cfg_q.data_bits <= cfg_wdata[msenc_pkg::NbitsWidth-1:0];
				end
				msenc_pkg::CFG_CHAR_OFFSET: begin
					cfg_q.char_offset <= cfg_wdata;
				end
				msenc_pkg::CFG_LEAD_ZEROS: begin
					cfg_q.leading_zero_count <= cfg_wdata[msenc_pkg::ZeroWidth-1:0];
				end
				msenc_pkg::CFG_TRAIL_ZEROS: begin
					cfg_q.trailing_zero_count <= cfg_wdata[msenc_pkg::ZeroWidth-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	msenc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.cmd    (front_cmd)
	);

	msenc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_cmd),
		.pop    (q_pop),
		.rdata  (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// The back end pops one command whenever it is idle and the queue holds one;
	// a reset-pole command clears the pole at that pop and produces no cell.
	msenc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.bitcell (bitcell),
		.empty   (empty),
		.pop     (pop),
		.status  (back_st)
	);

	// Every shown cell flips the pole at mid-cell exactly when it carries a one.
	`ASSERT_ALWAYS(a_cell_shape, clk, arst_n, empty || (bitcell.pole_second_half == (bitcell.pole_first_half ^ bitcell.cell_bit)))
	// A new cell is only produced when the output register is free or drains now.
	`ASSERT_ALWAYS(a_no_overwrite, clk, arst_n, !back_st.emit || empty || pop)
	// Cells come only from the serializing states.
	`ASSERT_ALWAYS(a_emit_busy, clk, arst_n, !back_st.emit || !back_st.idle)
	// An accepted command is always waiting in the queue on the next cycle.
	`ASSERT_NEXT(a_push_lands, clk, arst_n, push && !full, !q_empty)

endmodule

### tb/magstripe_f2f_track_encoder_core_tb.sv
`timescale 1ns / 100ps

// Checks the F2F track encoder against a cycle-free model of the same encoding.
// A driver offers queued commands with random gaps. A monitor pops bit cells
// with random stalls and compares each one with the oldest predicted cell. The
// registers are rewritten between phases, only once the encoder has drained.
module magstripe_f2f_track_encoder_core_tb;
	import msenc_pkg::*;

	localparam int ClkPeriod     = 8;
	localparam int ResetCycles   = 5;
	// A command passes through the queue before the serializer loads it.
	// A few queued commands that make no cells may still be in flight when the
	// last cell pops.
	localparam int SettleCycles  = 12;
	localparam int HoldOffCycles = 300;
	localparam int TargetCmds    = 230;
	// Reckoned from 39 cells per command, each cell waiting out the longest random
	// stall, and then taken several times over.
	localparam int TimeoutCycles = 2_000_000;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    push      = 1'b0;
	logic                    full;
	in_item_t                item      = '0;
	logic                    empty;
	logic                    pop       = 1'b0;
	out_item_t               bitcell;
	logic                    cfg_we    = 1'b0;
	cfg_idx_t                cfg_idx   = CFG_DATA_BITS;
	logic [CfgDataWidth-1:0] cfg_wdata = '0;

	// Encoder model: coil pole, running LRC and the four registers, all at reset.
	logic                  coil_pole_q = 1'b0;
	logic [LrcWidth-1:0]   lrc_q       = '0;
	logic [NbitsWidth-1:0] nbits_q     = DataBitsReset;
	logic [7:0]            offset_q    = CharOffsetReset;
	logic [ZeroWidth-1:0]  lead_q      = LeadReset;
	logic [ZeroWidth-1:0]  trail_q     = TrailReset;

	in_item_t  cmds_pending[$];
	out_item_t cells_due[$];

	int   err_cnt     = 0;
	int   cmds_queued = 0;
	int   drv_gap     = 0;
	int   drv_calm    = 0;
	int   rcv_gap     = 0;
	int   rcv_calm    = 0;
	int   hold_left   = 0;
	logic hold_req    = 1'b0;

	always #(ClkPeriod / 2) clk = ~clk;

	magstripe_f2f_track_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.bitcell   (bitcell),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	task automatic flag_error(input string msg);
		$display("%0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	// Most gaps are zero or short and a few are long. Now and then a side goes
	// calm for a while, so that long back-to-back stretches occur as well.
	task automatic pick_gap(inout int calm, output int gap);
		int r;
		r = $urandom_range(0, 99);
		if (calm != 0) begin
			calm--;
			gap = 0;
		end else if (r < 3) begin
			calm = $urandom_range(20, 80);
			gap = 0;
		end else if (r < 55) begin
			gap = 0;
		end else if (r < 92) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 40);
		end
	endtask

	// One F2F cell: the pole flips at the start of every cell and flips again at
	// mid-cell when the cell carries a one.
	task automatic push_cell(input logic bit_val, input logic last);
		out_item_t c;
		coil_pole_q = ~coil_pole_q;
		c.pole_first_half = coil_pole_q;
		if (bit_val) begin
			coil_pole_q = ~coil_pole_q;
		end
		c.pole_second_half = coil_pole_q;
		c.cell_bit = bit_val;
		c.last_cell = last;
		cells_due.push_back(c);
	endtask

	// The low nbits_q bits go out LSB first and then an odd parity cell. Data
	// characters fold each bit into the LRC; the LRC character itself does not.
	task automatic push_char(input logic [7:0] value, input logic fold,
			input logic parity_last);
		logic parity;
		parity = 1'b1;
		for (int i = 0; i < int'(nbits_q); i++) begin
			parity = parity ^ value[i];
			push_cell(value[i], 1'b0);
			if (fold) begin
				lrc_q[i] = lrc_q[i] ^ value[i];
			end
		end
		push_cell(parity, parity_last);
	endtask

	task automatic predict_cells(input in_item_t it);
		case (func_t'(it.func))
			FUNC_BEGIN: begin
				// With a lead count of zero nothing comes out, not even a last cell.
				lrc_q = '0;
				for (int i = 0; i < int'(lead_q); i++) begin
					push_cell(1'b0, i == int'(lead_q) - 1);
				end
			end
			FUNC_DATA: begin
				push_char(it.char_code - offset_q, 1'b1, 1'b1);
			end
			FUNC_END: begin
				push_char({1'b0, lrc_q}, 1'b0, trail_q == '0);
				for (int i = 0; i < int'(trail_q); i++) begin
					push_cell(1'b0, i == int'(trail_q) - 1);
				end
			end
			default: begin
				coil_pole_q = 1'b0;
			end
		endcase
	endtask

	task automatic check_bit(input string name, input logic got, input logic want);
		if (got !== want) begin
			flag_error($sformatf("%s got %b, expected %b", name, got, want));
		end
	endtask

	// The model's copy of a register changes as the write is issued. That is safe
	// because writes happen only while no command is in flight.
	task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataWidth-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_DATA_BITS:   nbits_q = val[NbitsWidth-1:0];
			CFG_CHAR_OFFSET: offset_q = val;
			CFG_LEAD_ZEROS:  lead_q = val[ZeroWidth-1:0];
			default:         trail_q = val[ZeroWidth-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] nbits, input logic [7:0] offset,
			input logic [7:0] lead, input logic [7:0] trail);
		write_reg(CFG_DATA_BITS, nbits);
		write_reg(CFG_CHAR_OFFSET, offset);
		write_reg(CFG_LEAD_ZEROS, lead);
		write_reg(CFG_TRAIL_ZEROS, trail);
		@(negedge clk);
	endtask

	// Sampling at the falling edge keeps this decision clear of the rising-edge
	// processes that move commands and cells.
	task automatic wait_drained();
		@(negedge clk);
		while (cmds_pending.size() != 0 || push || cells_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic queue_cmd(input func_t f, input logic [7:0] code);
		in_item_t it;
		it.func = f;
		it.char_code = code;
		cmds_pending.push_back(it);
		cmds_queued++;
	endtask

	// Mostly well-formed tracks, half of their characters inside the configured
	// alphabet; the rest is a short run of arbitrary commands.
	task automatic queue_random_burst(input logic force_track);
		int n;
		if (force_track || $urandom_range(0, 99) < 85) begin
			if ($urandom_range(0, 3) == 0) begin
				queue_cmd(FUNC_RESET_POLE, 8'($urandom));
			end
			queue_cmd(FUNC_BEGIN, 8'($urandom));
			n = force_track ? 12 : $urandom_range(1, 12);
			repeat (n) begin
				if ($urandom_range(0, 1) == 1) begin
					queue_cmd(FUNC_DATA,
						offset_q + 8'($urandom_range(0, (1 << nbits_q) - 1)));
				end else begin
					queue_cmd(FUNC_DATA, 8'($urandom));
				end
			end
			queue_cmd(FUNC_END, 8'($urandom));
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				queue_cmd(func_t'($urandom_range(FUNC_BEGIN, FUNC_RESET_POLE)),
					8'($urandom));
			end
		end
	endtask

	// Zero counts are mostly small so that tracks stay short; the maximum shows up
	// now and then. The unused upper bits of the write data are random.
	function automatic logic [7:0] pick_zeros();
		logic [4:0] z;
		z = ($urandom_range(0, 9) == 0) ? 5'd31 : 5'($urandom_range(0, 12));
		return {3'($urandom), z};
	endfunction

	function automatic logic [7:0] pick_offset();
		case ($urandom_range(0, 5))
			0:       return 8'd32;
			1:       return 8'd48;
			2:       return 8'd0;
			3:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// Driver. Every command that transfers is handed to the model at the same
	// edge, so predicted cells are always queued before the encoder can emit them.
	always @(posedge clk) begin : cmd_driver
		if (push && !full) begin
			predict_cells(item);
		end
		if (!push || !full) begin
			if (drv_gap != 0) begin
				drv_gap--;
				push <= 1'b0;
			end else if (cmds_pending.size() != 0) begin
				item <= cmds_pending.pop_front();
				push <= 1'b1;
				pick_gap(drv_calm, drv_gap);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor. It also carries out the long hold-off on request, counting the
	// cycles itself while the driver keeps offering commands.
	always @(posedge clk) begin : cell_monitor
		out_item_t want;
		if (pop && !empty) begin
			if (cells_due.size() == 0) begin
				flag_error($sformatf("cell %b arrived with none predicted", bitcell));
			end else begin
				want = cells_due.pop_front();
				check_bit("pole_first_half", bitcell.pole_first_half,
					want.pole_first_half);
				check_bit("pole_second_half", bitcell.pole_second_half,
					want.pole_second_half);
				check_bit("cell_bit", bitcell.cell_bit, want.cell_bit);
				check_bit("last_cell", bitcell.last_cell, want.last_cell);
			end
		end
		if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HoldOffCycles;
			pop <= 1'b0;
		end else if (rcv_gap != 0) begin
			rcv_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			pick_gap(rcv_calm, rcv_gap);
		end
	end

	initial begin : stimulus
		int phase;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: six data bits, offset 32. The characters cover an all-zero
		// and an all-one payload, both extremes of the code, and the wrap of the
		// subtraction. An end track and a data character then follow without a
		// begin track, so they work on the LRC left over from the track before.
		queue_cmd(FUNC_BEGIN, 8'h00);
		queue_cmd(FUNC_DATA, 8'h20);
		queue_cmd(FUNC_DATA, 8'h5F);
		queue_cmd(FUNC_DATA, 8'hFF);
		queue_cmd(FUNC_DATA, 8'h00);
		queue_cmd(FUNC_DATA, 8'h55);
		queue_cmd(FUNC_DATA, 8'hAA);
		queue_cmd(FUNC_END, 8'hFF);
		queue_cmd(FUNC_RESET_POLE, 8'h00);
		queue_cmd(FUNC_END, 8'h00);
		queue_cmd(FUNC_DATA, 8'h41);
		queue_cmd(FUNC_RESET_POLE, 8'hFF);
		wait_drained();

		// No data bits and no zeros at all: the begin track makes no cell, and
		// each character is a lone parity cell that carries a one.
		set_config(8'hF8, 8'h00, 8'h00, 8'h00);
		queue_cmd(FUNC_BEGIN, 8'h00);
		queue_cmd(FUNC_DATA, 8'h5A);
		queue_cmd(FUNC_END, 8'h00);
		queue_cmd(FUNC_RESET_POLE, 8'h00);
		wait_drained();

		// Widest characters, largest offset, longest lead and trail.
		set_config(8'h07, 8'hFF, 8'h1F, 8'h1F);
		queue_cmd(FUNC_BEGIN, 8'h00);
		queue_cmd(FUNC_DATA, 8'h7F);
		queue_cmd(FUNC_DATA, 8'hFE);
		queue_cmd(FUNC_DATA, 8'h00);
		queue_cmd(FUNC_END, 8'h00);
		wait_drained();

		// Numeric track: four data bits, offset of an ASCII zero.
		set_config(8'h04, 8'h30, 8'h0A, 8'h0A);
		queue_cmd(FUNC_BEGIN, 8'h00);
		queue_cmd(FUNC_DATA, 8'h39);
		queue_cmd(FUNC_DATA, 8'h3F);
		queue_cmd(FUNC_END, 8'h00);

		phase = 0;
		while (cmds_queued < TargetCmds) begin
			wait_drained();
			set_config({5'($urandom),
				3'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
					: $urandom_range(4, 7))},
				pick_offset(), pick_zeros(), pick_zeros());
			if (phase == 1) begin
				// The receiver holds off while a full track is offered, so that the
				// encoder backs up and stalls its input.
				hold_req = 1'b1;
				queue_random_burst(1'b1);
			end
			repeat ($urandom_range(1, 3)) queue_random_burst(1'b0);
			phase++;
		end
		wait_drained();

		if (cells_due.size() != 0) begin
			flag_error($sformatf("%0d predicted cells never arrived", cells_due.size()));
		end
		if (err_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : watchdog
		#(TimeoutCycles * ClkPeriod);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
